@@ design/sampled_hot_key_detector_unit_defines.svh @@
// assertion macros shared by shkd_dp and shkd_ctrl
`ifndef SAMPLED_HOT_KEY_DETECTOR_UNIT_DEFINES_SVH
`define SAMPLED_HOT_KEY_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, checked after reset
`define SHKD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked after reset
`define SHKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/shkd_pkg.sv @@
`timescale 1ns / 1ps
package shkd_pkg;

    localparam int WINDOW_DEPTH  = 1024;
    localparam int KEY_HASH_BITS = 32;
    localparam int IDX_W         = $clog2(WINDOW_DEPTH);
    localparam int OCC_W         = $clog2(WINDOW_DEPTH + 1);

    localparam logic [63:0] USEC_PER_SEC = 64'd1000000;
    localparam logic [10:0] MAX_RATE     = 11'd1024;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_ADDR_W = 3;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SAMPLE_RATE = 3'd0,
        CFG_WINDOW_SIZE = 3'd1,
        CFG_REDLINE_QPS = 3'd2,
        CFG_COUNT_THR   = 3'd3,
        CFG_BW_THR      = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_RATE = 2'd1,
        VERDICT_BW   = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [31:0] key_hash;
        logic [7:0]  key_length;
        logic [20:0] value_length;
        logic [63:0] time_usec;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        sampled;
        logic [10:0] key_count;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_run;
        logic pop;
        logic mul1;
        logic mul2;
        logic mul3;
        logic div_start;
        logic decide;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sample;
        logic scan_done;
        logic pop_need;
        logic div_busy;
    } t_sts;

endpackage

@@ design/shkd_div.sv @@
`timescale 1ns / 1ps
module shkd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quotient
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        ge;

    // one restoring step
    always_comb begin
        rem_sh  = {r_rem, r_quo[63]};
        rem_sub = rem_sh - {1'b0, i_divisor};
        ge      = (rem_sh >= {1'b0, i_divisor});
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[63:0] : rem_sh[63:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

@@ design/shkd_dp.sv @@
`timescale 1ns / 1ps
`include "sampled_hot_key_detector_unit_defines.svh"
module shkd_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [shkd_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [shkd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  shkd_pkg::t_in_word                   i_in_word,
    input  shkd_pkg::t_cmd                       i_cmd,
    output shkd_pkg::t_sts                       o_sts,
    output shkd_pkg::t_out_word                  o_out_word
);

    localparam int IW    = shkd_pkg::IDX_W;
    localparam int OW    = shkd_pkg::OCC_W;
    localparam int KW    = shkd_pkg::KEY_HASH_BITS;
    localparam int DEPTH = shkd_pkg::WINDOW_DEPTH;
    localparam int PB1_W = OW + 22;
    localparam int PB2_W = PB1_W + 11;

    // configuration
    logic [10:0] r_sample_rate;
    logic [10:0] r_window_size;
    logic [31:0] r_redline;
    logic [10:0] r_count_thr;
    logic [47:0] r_bw_thr;

    // window control
    logic [9:0]  r_get_cnt;
    logic [OW-1:0] r_occ;
    logic [IW-1:0] r_head;
    logic [OW-1:0] r_scan_idx;
    logic          r_rd_vld;

    // item payload
    logic [KW-1:0] r_key;
    logic [63:0]   r_now;
    logic [21:0]   r_len;
    logic [OW-1:0] r_count;
    logic          r_sampled;
    shkd_pkg::t_verdict r_verdict;
    logic [63:0]   r_diff;
    logic [21:0]   r_pq;
    logic [PB1_W-1:0] r_pb1;
    logic [PB2_W-1:0] r_pb2;
    logic [63:0]   r_qps_num;
    logic [63:0]   r_bw_num;
    shkd_pkg::t_out_word r_out;

    // window memories
    logic [KW-1:0] r_key_mem [DEPTH];
    logic [63:0]   r_time_mem [DEPTH];
    logic [KW-1:0] r_key_rd;
    logic [63:0]   r_time_rd;

    logic [10:0]   rate_eff;
    logic [10:0]   wsize_eff;
    logic          is_sample;
    logic [IW-1:0] slot;
    logic [IW-1:0] scan_addr;
    logic [KW-1:0] in_key;
    logic [63:0]   elapsed;
    logic          qps_busy;
    logic          bw_busy;
    logic [63:0]   qps;
    logic [63:0]   bw;

    // ring index wrap, sum stays below twice the depth
    function automatic logic [IW-1:0] wrap_idx(input logic [IW:0] s);
        logic [IW:0] t;
        t = (32'(s) >= 32'(DEPTH)) ? (s - (IW+1)'(DEPTH)) : s;
        return t[IW-1:0];
    endfunction

    // effective settings and sampling decision
    always_comb begin
        if (r_sample_rate == 11'd0) begin
            rate_eff = 11'd1;
        end else if (r_sample_rate > shkd_pkg::MAX_RATE) begin
            rate_eff = shkd_pkg::MAX_RATE;
        end else begin
            rate_eff = r_sample_rate;
        end
        if (r_window_size == 11'd0) begin
            wsize_eff = 11'd1;
        end else if (32'(r_window_size) > 32'(DEPTH)) begin
            wsize_eff = 11'(DEPTH);
        end else begin
            wsize_eff = r_window_size;
        end
        is_sample = (({1'b0, r_get_cnt} + 11'd1) >= rate_eff);
        slot      = wrap_idx((IW+1)'(r_head) + (IW+1)'(r_occ));
        scan_addr = wrap_idx((IW+1)'(r_head) + (IW+1)'(r_scan_idx));
        in_key    = KW'(i_in_word.key_hash);
        elapsed   = r_now - r_time_rd;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= 11'd100;
            r_window_size <= 11'd1000;
            r_redline     <= 32'd100000;
            r_count_thr   <= 11'd10;
            r_bw_thr      <= 48'd2500000;
        end else if (i_cfg_we) begin
            unique case (shkd_pkg::t_cfg_idx'(i_cfg_addr))
                shkd_pkg::CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[10:0];
                shkd_pkg::CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[10:0];
                shkd_pkg::CFG_REDLINE_QPS: r_redline     <= i_cfg_data[31:0];
                shkd_pkg::CFG_COUNT_THR:   r_count_thr   <= i_cfg_data[10:0];
                shkd_pkg::CFG_BW_THR:      r_bw_thr      <= i_cfg_data[47:0];
                default: begin
                end
            endcase
        end
    end

    // memories: push at a sampled accept, key scan and oldest time reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_sample) begin
            r_key_mem[slot]  <= in_key;
            r_time_mem[slot] <= i_in_word.time_usec;
        end
        r_key_rd  <= r_key_mem[scan_addr];
        r_time_rd <= r_time_mem[r_head];
    end

    // window control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_get_cnt  <= '0;
            r_occ      <= '0;
            r_head     <= '0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_get_cnt  <= is_sample ? 10'd0 : (r_get_cnt + 10'd1);
                r_scan_idx <= '0;
                r_rd_vld   <= 1'b0;
                if (is_sample) begin
                    r_occ <= r_occ + OW'(1);
                end
            end else if (i_cmd.scan_run) begin
                if (r_scan_idx < r_occ) begin
                    r_scan_idx <= r_scan_idx + OW'(1);
                    r_rd_vld   <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end else if (i_cmd.pop) begin
                r_head <= (32'(r_head) == DEPTH - 1) ? '0 : (r_head + IW'(1));
                r_occ  <= r_occ - OW'(1);
            end
        end
    end

    // item payload and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key     <= in_key;
            r_now     <= i_in_word.time_usec;
            r_len     <= 22'(i_in_word.key_length) + 22'(i_in_word.value_length);
            r_count   <= '0;
            r_sampled <= is_sample;
            r_verdict <= shkd_pkg::VERDICT_NONE;
        end
        if (i_cmd.scan_run && r_rd_vld && (r_key_rd == r_key)) begin
            r_count <= r_count + OW'(1);
        end
        if (i_cmd.pop) begin
            r_diff <= (elapsed == 64'd0) ? 64'd1 : elapsed;
        end
        if (i_cmd.mul1) begin
            r_pq  <= 22'(wsize_eff) * 22'(rate_eff);
            r_pb1 <= PB1_W'(r_count) * PB1_W'(r_len);
        end
        if (i_cmd.mul2) begin
            r_qps_num <= 64'(r_pq) * shkd_pkg::USEC_PER_SEC;
            r_pb2     <= PB2_W'(r_pb1) * PB2_W'(rate_eff);
        end
        if (i_cmd.mul3) begin
            r_bw_num <= 64'(r_pb2) * shkd_pkg::USEC_PER_SEC;
        end
        if (i_cmd.decide) begin
            if ((qps >= {32'd0, r_redline}) && (32'(r_count) >= 32'(r_count_thr))) begin
                r_verdict <= shkd_pkg::VERDICT_RATE;
            end else if (bw >= {16'd0, r_bw_thr}) begin
                r_verdict <= shkd_pkg::VERDICT_BW;
            end else begin
                r_verdict <= shkd_pkg::VERDICT_NONE;
            end
        end
        if (i_cmd.load_out) begin
            r_out.verdict   <= r_verdict;
            r_out.sampled   <= r_sampled;
            r_out.key_count <= 11'(r_count);
        end
    end

    // rate and bandwidth dividers
    shkd_div u_div_qps (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_qps_num),
        .i_divisor  (r_diff),
        .o_busy     (qps_busy),
        .o_quotient (qps)
    );

    shkd_div u_div_bw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_bw_num),
        .i_divisor  (r_diff),
        .o_busy     (bw_busy),
        .o_quotient (bw)
    );

    // status to controller
    always_comb begin
        o_sts.sample    = is_sample;
        o_sts.scan_done = (r_scan_idx == r_occ) && !r_rd_vld;
        o_sts.pop_need  = (32'(r_occ) >= 32'(wsize_eff));
        o_sts.div_busy  = qps_busy || bw_busy;
    end

    assign o_out_word = r_out;

    `SHKD_ASSERT_NOW(a_occ_bound, 1'b1, 32'(r_occ) <= DEPTH, "window fill above depth")
    `SHKD_ASSERT_NEXT(a_pop_room, i_cmd.pop, 32'(r_occ) < DEPTH, "fill at depth after pop")
    `SHKD_ASSERT_NOW(a_scan_bound, i_cmd.scan_run, r_scan_idx <= r_occ, "scan ran past window fill")

endmodule

@@ design/shkd_ctrl.sv @@
`timescale 1ns / 1ps
`include "sampled_hot_key_detector_unit_defines.svh"
module shkd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  shkd_pkg::t_sts i_sts,
    output shkd_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DECIDE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.sample ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.pop_need) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_MUL1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `SHKD_ASSERT_NEXT(a_done_loads, (r_state == S_DONE) && out_free, r_out_valid, "result not shown")
    `SHKD_ASSERT_NOW(a_idle_div, r_state == S_IDLE, !i_sts.div_busy, "divider busy while idle")
    `SHKD_ASSERT_NOW(a_pop_need, o_cmd.pop, i_sts.pop_need, "pop without full window")

endmodule

@@ design/sampled_hot_key_detector_unit.sv @@
`timescale 1ns / 1ps
// sampled hot key detector
// input channel: one cache get per word (key hash, key and value length, time in usec),
// accepted when i_in_valid is high and o_in_stall is low
// output channel: one result word per get (verdict, sampled flag, key count),
// taken when o_out_valid is high and i_out_stall is low
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_addr; the user must write it
// only while the block is idle, since the block itself does not enforce this
// sequence from accept to o_out_valid: a get that is not sampled goes straight to the result;
// a sampled get first scans the window, one entry per cycle from the key memory, over the fill
// counted after the push, then checks whether a pop is needed; without a pop the result
// follows the scan, with a pop come the multiply steps S_MUL1, S_MUL2 and S_MUL3, the
// divider start, the bit-per-cycle dividers and the compare
// one get at a time; the next get can be taken in the cycle after the result is loaded,
// and the sampled gets set the average rate
// reset: clears the get counter and the window fill and head, loads the register
// defaults; the window memories are not cleared, entries are read only once written
// when the receiver stalls the result holds in the output register, the next
// result waits in the controller and the input stalls
module sampled_hot_key_detector_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  shkd_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output shkd_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_we,
    input  logic [shkd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [shkd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    shkd_pkg::t_cmd cmd;
    shkd_pkg::t_sts sts;

    // sequencer
    shkd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // window, arithmetic and result register
    shkd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule

@@ tb/sv/shkd_checker.sv @@
`timescale 1ns / 1ps
module shkd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  shkd_pkg::t_in_word              i_in_word,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  shkd_pkg::t_out_word             i_out_word,
    input  logic                            i_cfg_we,
    input  logic [shkd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [shkd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    // shadow registers and window
    logic [10:0] rate_reg, wsize_reg, cthr_reg;
    logic [31:0] redline_reg;
    logic [47:0] bwthr_reg;
    logic [63:0] get_cnt;
    logic [31:0] win_key [shkd_pkg::WINDOW_DEPTH];
    logic [63:0] win_time [shkd_pkg::WINDOW_DEPTH];
    int          win_fill, win_head;

    shkd_pkg::t_out_word result_q[$];

    assign o_pending = result_q.size();

    function automatic logic [63:0] clamp(logic [63:0] v, logic [63:0] hi);
        if (v < 64'd1) return 64'd1;
        if (v > hi) return hi;
        return v;
    endfunction

    // predict the result word of one get
    task automatic predict_get(input shkd_pkg::t_in_word w, output shkd_pkg::t_out_word r);
        logic [63:0] rate, wsz, cnt, oldest, diff, qps, bw, klen, vlen;
        int          slot, idx;
        rate = clamp(64'(rate_reg), 64'd1024);
        wsz  = clamp(64'(wsize_reg), 64'(shkd_pkg::WINDOW_DEPTH));
        r = '0;
        if (get_cnt + 64'd1 < rate) begin
            get_cnt = get_cnt + 64'd1;
            return;
        end
        get_cnt = 64'd0;
        slot = (win_head + win_fill) % shkd_pkg::WINDOW_DEPTH;
        win_key[slot] = w.key_hash;
        win_time[slot] = w.time_usec;
        win_fill++;
        cnt = 64'd0;
        for (int i = 0; i < win_fill; i++) begin
            idx = (win_head + i) % shkd_pkg::WINDOW_DEPTH;
            if (win_key[idx] == w.key_hash) cnt++;
        end
        r.sampled = 1'b1;
        r.key_count = cnt[10:0];
        if (64'(win_fill) >= wsz) begin
            oldest = win_time[win_head];
            win_head = (win_head + 1) % shkd_pkg::WINDOW_DEPTH;
            win_fill--;
            diff = w.time_usec - oldest;
            if (diff == 64'd0) diff = 64'd1;
            klen = 64'(w.key_length);
            vlen = 64'(w.value_length);
            qps = (wsz * rate * 64'd1000000) / diff;
            bw = (cnt * (klen + vlen) * rate * 64'd1000000) / diff;
            if (qps >= 64'(redline_reg) && cnt >= 64'(cthr_reg))
                r.verdict = shkd_pkg::VERDICT_RATE;
            else if (bw >= 64'(bwthr_reg))
                r.verdict = shkd_pkg::VERDICT_BW;
        end
    endtask

    always @(posedge i_clk) begin
        shkd_pkg::t_out_word p, e;
        if (!i_rst_n) begin
            rate_reg = 11'd100; wsize_reg = 11'd1000; redline_reg = 32'd100000;
            cthr_reg = 11'd10; bwthr_reg = 48'd2500000;
            get_cnt = 64'd0; win_fill = 0; win_head = 0;
            o_fail_count = 0;
            result_q.delete();
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    shkd_pkg::CFG_SAMPLE_RATE: rate_reg = i_cfg_data[10:0];
                    shkd_pkg::CFG_WINDOW_SIZE: wsize_reg = i_cfg_data[10:0];
                    shkd_pkg::CFG_REDLINE_QPS: redline_reg = i_cfg_data[31:0];
                    shkd_pkg::CFG_COUNT_THR:   cthr_reg = i_cfg_data[10:0];
                    shkd_pkg::CFG_BW_THR:      bwthr_reg = i_cfg_data[47:0];
                    default: ;
                endcase
            end
            // accepted get word
            if (i_in_valid && !i_in_stall) begin
                predict_get(i_in_word, p);
                result_q.push_back(p);
            end
            // accepted result word
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word %p", i_out_word);
                end else begin
                    e = result_q.pop_front();
                    if (e !== i_out_word) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p actual %p", e, i_out_word);
                    end
                end
            end
        end
    end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;

    logic      i_clk = 0, i_rst_n = 0;
    logic      in_valid = 0, out_stall = 0, cfg_we = 0;
    logic      in_stall, out_valid;
    shkd_pkg::t_in_word  in_word = '0;
    shkd_pkg::t_out_word out_word;
    logic [shkd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [shkd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int        fail_count, pending;
    int        send_idle = 0, recv_stall = 0;
    bit        hold_off = 0;
    longint    cycles = 0;
    logic [63:0] now_us = 0;
    logic [31:0] hot_keys [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A};

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    sampled_hot_key_detector_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    shkd_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 10000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_stall);
    end

    task automatic write_reg(input shkd_pkg::t_cfg_idx idx, input logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all results, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    // offer one get word and wait for its acceptance
    task automatic send_get(input shkd_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    function automatic shkd_pkg::t_in_word rand_get(int mode);
        shkd_pkg::t_in_word w;
        w.key_hash = ($urandom_range(3) != 0) ? hot_keys[$urandom_range(3)] : $urandom;
        w.key_length = 8'($urandom);
        w.value_length = ($urandom_range(9) == 0) ? 21'd1048576
                                                  : 21'($urandom_range(1048576));
        if (mode == 0) now_us = now_us + 64'($urandom_range(3));
        else if (mode == 1) now_us = {$urandom, $urandom};
        else now_us = now_us + 64'($urandom_range(200000));
        w.time_usec = now_us;
        return w;
    endfunction

    task automatic set_all(input logic [47:0] sr, ws, rq, ct, bt);
        write_reg(shkd_pkg::CFG_SAMPLE_RATE, sr);
        write_reg(shkd_pkg::CFG_WINDOW_SIZE, ws);
        write_reg(shkd_pkg::CFG_REDLINE_QPS, rq);
        write_reg(shkd_pkg::CFG_COUNT_THR, ct);
        write_reg(shkd_pkg::CFG_BW_THR, bt);
    endtask

    initial begin
        shkd_pkg::t_in_word w;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small window, every get sampled, field extremes
        set_all(48'd1, 48'd3, 48'd1000, 48'd1, 48'd1000);
        w = '0; send_get(w);
        w = '1; send_get(w);
        w = '0; w.time_usec = 64'd5; send_get(w);
        w = '0; w.time_usec = 64'd5; send_get(w);     // same time as the previous get
        w = '0; w.time_usec = 64'd1; send_get(w);     // time backwards
        w.key_hash = '1; w.key_length = 8'hFF; w.value_length = 21'd1048576;
        w.time_usec = 64'd2; send_get(w);
        w.time_usec = '1; send_get(w);
        drain();
        // clamp cases: zero rate and size, oversize values, full thresholds
        set_all(48'd0, 48'd0, 48'hFFFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++) send_get(rand_get(0));
        drain();
        set_all(48'h7FF, 48'h7FF, 48'd0, 48'h7FF, 48'd0);
        for (int i = 0; i < 4; i++) send_get(rand_get(0));
        drain();
        // counter above a lowered rate
        set_all(48'd7, 48'd2, 48'd0, 48'd0, 48'd0);
        for (int i = 0; i < 5; i++) send_get(rand_get(2));
        drain();
        write_reg(shkd_pkg::CFG_SAMPLE_RATE, 48'd2);
        send_get(rand_get(2));
        send_get(rand_get(2));
        drain();

        // random phases with varying settings and idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 55; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 55; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            // window size lowered below fill in some phases
            set_all(48'($urandom_range(3) + 1),
                    (ph == 7) ? 48'd1024 : 48'($urandom_range(40) + 1),
                    $urandom_range(1) ? 48'($urandom_range(2000000)) : 48'($urandom),
                    48'($urandom_range(12)),
                    $urandom_range(1) ? 48'($urandom_range(50000000))
                                      : 48'({$urandom_range(65535), $urandom}));
            if (ph == 2) fork
                begin
                    hold_off = 1;
                    repeat (800) @(posedge i_clk);
                    hold_off = 0;
                end
            join_none
            for (int i = 0; i < 170; i++) send_get(rand_get($urandom_range(2)));
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+design
design/shkd_pkg.sv
design/shkd_div.sv
design/shkd_dp.sv
design/shkd_ctrl.sv
design/sampled_hot_key_detector_unit.sv
tb/sv/shkd_checker.sv
tb/sv/tb.sv
